// ===== hdl/akga_pkg.sv =====
// Shared constants, register codes and interface types for the analog key to gamepad axes block.
package akga_pkg;

    localparam int TRAVEL_MAX = 40;
    localparam int MAG_W      = 15;
    localparam int DIV_STEPS  = 16;

    localparam logic [MAG_W-1:0] FULL_MAG   = 15'd32767;
    localparam logic [3:0]       SMOOTH_MAX = 4'd10;

    localparam logic [1:0] TGT_LEFT  = 2'd0;
    localparam logic [1:0] TGT_RIGHT = 2'd1;
    localparam logic [1:0] TGT_TRIG  = 2'd2;

    localparam logic [1:0] CURVE_LIN    = 2'd0;
    localparam logic [1:0] CURVE_SQR    = 2'd1;
    localparam logic [1:0] CURVE_SMOOTH = 2'd2;

    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_TARGET     = 3'd1;
    localparam logic [2:0] REG_CURVE      = 3'd2;
    localparam logic [2:0] REG_DEAD_ZONE  = 3'd3;
    localparam logic [2:0] REG_FULL_SCALE = 3'd4;
    localparam logic [2:0] REG_SMOOTHING  = 3'd5;
    localparam logic [2:0] REG_FLIP_X     = 3'd6;
    localparam logic [2:0] REG_FLIP_Y     = 3'd7;

    typedef struct packed {
        logic [7:0] dead_zone;
        logic [7:0] full_scale;
        logic [1:0] curve;
    } lane_cfg_t;

    typedef struct packed {
        logic [3:0] smoothing;
        logic       flip_x;
        logic       flip_y;
    } merge_cfg_t;

    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic [7:0]         lt;
        logic [7:0]         rt;
    } merge_res_t;

endpackage

// ===== hdl/akga_lane.sv =====
// Per-key magnitude lane: deadzone, full scale, response curve and serial divide.
module akga_lane import akga_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [7:0]       travel,
    input  lane_cfg_t        cfg,
    output logic             done,
    output logic [MAG_W-1:0] mag
);

    typedef enum logic [2:0] {L_IDLE, L_MUL, L_NUM, L_DIV, L_DONE} lstate_t;

    lstate_t          state_reg;
    logic [7:0]       p_reg;
    logic [7:0]       s_reg;
    logic [15:0]      pp_reg;
    logic [15:0]      ss_reg;
    logic [9:0]       w_reg;
    logic [23:0]      den_reg;
    logic [40:0]      rem_reg;
    logic [3:0]       cnt_reg;
    logic [MAG_W-1:0] mag_reg;

    logic [7:0]  sat;
    logic [25:0] x_next;
    logic [23:0] den_next;
    logic [40:0] num_next;
    logic [40:0] trial;
    logic        ge;

    always_comb
    begin
        sat = (cfg.full_scale > 8'(TRAVEL_MAX)) ? 8'(TRAVEL_MAX) : cfg.full_scale;
        case (cfg.curve)
            CURVE_SQR:
            begin
                x_next   = 26'(pp_reg);
                den_next = 24'(ss_reg);
            end
            CURVE_SMOOTH:
            begin
                x_next   = 26'(pp_reg * w_reg);
                den_next = 24'(ss_reg * s_reg);
            end
            default:
            begin
                x_next   = 26'(p_reg);
                den_next = 24'(s_reg);
            end
        endcase
        num_next = {x_next, 15'd0} - 41'(x_next);
        trial    = 41'(den_reg) << cnt_reg;
        ge       = (rem_reg >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE, L_DONE:
                begin
                    if (start)
                    begin
                        if (cfg.dead_zone >= sat || travel <= cfg.dead_zone || travel >= sat)
                            state_reg <= L_DONE;
                        else
                            state_reg <= L_MUL;
                    end
                end
                L_MUL:
                    state_reg <= L_NUM;
                L_NUM:
                    state_reg <= L_DIV;
                L_DIV:
                begin
                    if (cnt_reg == 4'd0)
                        state_reg <= L_DONE;
                end
                default:
                    state_reg <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE, L_DONE:
            begin
                if (start)
                begin
                    p_reg   <= travel - cfg.dead_zone;
                    s_reg   <= sat - cfg.dead_zone;
                    mag_reg <= '0;
                    if (cfg.dead_zone < sat && travel > cfg.dead_zone && travel >= sat)
                        mag_reg <= FULL_MAG;
                end
            end
            L_MUL:
            begin
                pp_reg <= 16'(p_reg * p_reg);
                ss_reg <= 16'(s_reg * s_reg);
                w_reg  <= ({2'b00, s_reg} + {1'b0, s_reg, 1'b0}) - {1'b0, p_reg, 1'b0};
            end
            L_NUM:
            begin
                den_reg <= den_next;
                rem_reg <= num_next;
                cnt_reg <= 4'(MAG_W - 1);
            end
            L_DIV:
            begin
                if (ge)
                    rem_reg <= rem_reg - trial;
                mag_reg <= {mag_reg[MAG_W-2:0], ge};
                cnt_reg <= cnt_reg - 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == L_DONE);
    assign mag  = mag_reg;

endmodule

// ===== hdl/akga_merge.sv =====
// Merge stage: axis targets, smoothing filter step over serial dividers and trigger scaling.
module akga_merge import akga_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MAG_W-1:0]   nx,
    input  logic [MAG_W-1:0]   px,
    input  logic [MAG_W-1:0]   ny,
    input  logic [MAG_W-1:0]   py,
    input  merge_cfg_t         cfg,
    input  logic signed [15:0] fx,
    input  logic signed [15:0] fy,
    output logic               done,
    output merge_res_t         res
);

    typedef enum logic [1:0] {M_IDLE, M_DIV, M_DONE} mstate_t;

    mstate_t            state_reg;
    logic [4:0]         cnt_reg;
    logic [DIV_STEPS-1:0] nd_reg  [2];
    logic [DIV_STEPS-1:0] q_reg   [2];
    logic [15:0]        rem_reg [2];
    logic [15:0]        dv_reg  [2];
    logic signed [15:0] tx_reg;
    logic signed [15:0] ty_reg;
    logic               negx_reg;
    logic               negy_reg;
    logic               nzx_reg;
    logic               nzy_reg;
    logic               bypass_reg;
    logic [7:0]         lt_reg;
    logic [7:0]         rt_reg;

    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0]        ax;
    logic [16:0]        ay;
    logic [3:0]         lvl;
    logic [MAG_W-1:0]   lmax;
    logic [MAG_W-1:0]   rmax;
    logic [16:0]        sh   [2];
    logic               ge   [2];
    logic [15:0]        stx;
    logic [15:0]        sty;
    logic signed [16:0] nfx;
    logic signed [16:0] nfy;

    // m * 255 / 32767 as (x + x / 32768 + 1) / 32768 with x = m * 255
    function automatic logic [7:0] scale_trigger(logic [MAG_W-1:0] m);
        logic [23:0] x;
        logic [23:0] y;
        x = {1'b0, m, 8'd0} - 24'(m);
        y = x + 24'(x[23:15]) + 24'd1;
        return y[22:15];
    endfunction

    always_comb
    begin
        tx = $signed({1'b0, px}) - $signed({1'b0, nx});
        ty = $signed({1'b0, py}) - $signed({1'b0, ny});
        if (cfg.flip_x)
            tx = -tx;
        if (cfg.flip_y)
            ty = -ty;
        dx   = 17'(tx) - 17'(fx);
        dy   = 17'(ty) - 17'(fy);
        ax   = dx[16] ? -dx : dx;
        ay   = dy[16] ? -dy : dy;
        lvl  = (cfg.smoothing > SMOOTH_MAX) ? SMOOTH_MAX : cfg.smoothing;
        lmax = (nx > ny) ? nx : ny;
        rmax = (px > py) ? px : py;
        for (int k = 0; k < 2; k++)
        begin
            sh[k] = {rem_reg[k], nd_reg[k][DIV_STEPS-1]};
            ge[k] = (sh[k] >= {1'b0, dv_reg[k]});
        end
        stx = (q_reg[0][15:0] == 16'd0 && nzx_reg) ? 16'd1 : q_reg[0][15:0];
        sty = (q_reg[1][15:0] == 16'd0 && nzy_reg) ? 16'd1 : q_reg[1][15:0];
        nfx = negx_reg ? 17'(fx) - 17'(stx) : 17'(fx) + 17'(stx);
        nfy = negy_reg ? 17'(fy) - 17'(sty) : 17'(fy) + 17'(sty);
        res.fx = bypass_reg ? tx_reg : nfx[15:0];
        res.fy = bypass_reg ? ty_reg : nfy[15:0];
        res.lt = lt_reg;
        res.rt = rt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
        end
        else
        begin
            unique case (state_reg)
                M_IDLE, M_DONE:
                begin
                    if (start)
                        state_reg <= M_DIV;
                end
                M_DIV:
                begin
                    if (cnt_reg == 5'd0)
                        state_reg <= M_DONE;
                end
                default:
                    state_reg <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg != M_DIV && start)
        begin
            tx_reg     <= tx;
            ty_reg     <= ty;
            negx_reg   <= dx[16];
            negy_reg   <= dy[16];
            nzx_reg    <= (dx != 17'sd0);
            nzy_reg    <= (dy != 17'sd0);
            bypass_reg <= (lvl == 4'd0);
            lt_reg     <= scale_trigger(lmax);
            rt_reg     <= scale_trigger(rmax);
            nd_reg[0]  <= DIV_STEPS'(ax[15:0]);
            nd_reg[1]  <= DIV_STEPS'(ay[15:0]);
            dv_reg[0]  <= 16'(lvl) + 16'd1;
            dv_reg[1]  <= 16'(lvl) + 16'd1;
            for (int k = 0; k < 2; k++)
            begin
                rem_reg[k] <= '0;
                q_reg[k]   <= '0;
            end
            cnt_reg <= 5'(DIV_STEPS - 1);
        end
        else if (state_reg == M_DIV)
        begin
            for (int k = 0; k < 2; k++)
            begin
                rem_reg[k] <= ge[k] ? 16'(sh[k] - {1'b0, dv_reg[k]}) : sh[k][15:0];
                nd_reg[k]  <= {nd_reg[k][DIV_STEPS-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k][DIV_STEPS-2:0], ge[k]};
            end
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    assign done = (state_reg == M_DONE);

endmodule

// ===== hdl/analog_key_to_gamepad_axes_core.sv =====
// Top level: configuration registers, four magnitude lanes, merge stage and result register.
// A frame transfer starts four lanes in parallel; a lane whose travel is in the deadzone or at
// full scale goes straight to done, the others run a multiply step, a multiply-and-load step and
// a 15-step restoring divide. The merge stage then loads and runs a 16-step divide for the filter
// step, with trigger scaling done at load, before the result register loads. One frame is in
// work at a time; the next frame can transfer in the cycle after the result is loaded, and a held
// result stalls its load and with it the input. With enable low the result is all zero and the
// filters hold.
module analog_key_to_gamepad_axes_core import akga_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         travel_x_negative,
    input  logic [7:0]         travel_x_positive,
    input  logic [7:0]         travel_y_negative,
    input  logic [7:0]         travel_y_positive,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] left_stick_x,
    output logic signed [15:0] left_stick_y,
    output logic signed [15:0] right_stick_x,
    output logic signed [15:0] right_stick_y,
    output logic [7:0]         trig_left,
    output logic [7:0]         trig_right
);

    typedef enum logic [1:0] {T_IDLE, T_LANE, T_MERGE} tstate_t;

    tstate_t            state_reg;
    logic               enable_reg;
    logic [1:0]         target_reg;
    logic [1:0]         curve_reg;
    logic [7:0]         dead_zone_reg;
    logic [7:0]         full_scale_reg;
    logic [3:0]         smoothing_reg;
    logic               flip_x_reg;
    logic               flip_y_reg;
    logic signed [15:0] fx_reg;
    logic signed [15:0] fy_reg;
    logic               out_valid_reg;
    logic signed [15:0] lsx_reg;
    logic signed [15:0] lsy_reg;
    logic signed [15:0] rsx_reg;
    logic signed [15:0] rsy_reg;
    logic [7:0]         lt_reg;
    logic [7:0]         rt_reg;

    logic             in_xfer;
    logic             lane_done [4];
    logic [MAG_W-1:0] lane_mag  [4];
    logic [7:0]       lane_travel [4];
    lane_cfg_t        lcfg;
    merge_cfg_t       mcfg;
    merge_res_t       mres;
    logic             merge_start;
    logic             merge_done;
    logic             out_write;

    assign in_xfer        = in_valid && !in_stall;
    assign in_stall       = (state_reg != T_IDLE);
    assign lane_travel[0] = travel_x_negative;
    assign lane_travel[1] = travel_x_positive;
    assign lane_travel[2] = travel_y_negative;
    assign lane_travel[3] = travel_y_positive;
    assign lcfg           = '{dead_zone: dead_zone_reg, full_scale: full_scale_reg,
                              curve: curve_reg};
    assign mcfg           = '{smoothing: smoothing_reg, flip_x: flip_x_reg,
                              flip_y: flip_y_reg};
    assign merge_start    = (state_reg == T_LANE) && lane_done[0] && lane_done[1]
                            && lane_done[2] && lane_done[3];
    assign out_write      = (state_reg == T_MERGE) && merge_done
                            && (!out_valid_reg || !out_stall);

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        akga_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (in_xfer),
            .travel (lane_travel[g]),
            .cfg    (lcfg),
            .done   (lane_done[g]),
            .mag    (lane_mag[g])
        );
    end

    akga_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .start (merge_start),
        .nx    (lane_mag[0]),
        .px    (lane_mag[1]),
        .ny    (lane_mag[2]),
        .py    (lane_mag[3]),
        .cfg   (mcfg),
        .fx    (fx_reg),
        .fy    (fy_reg),
        .done  (merge_done),
        .res   (mres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            enable_reg     <= 1'b1;
            target_reg     <= TGT_LEFT;
            curve_reg      <= CURVE_LIN;
            dead_zone_reg  <= 8'd1;
            full_scale_reg <= 8'd40;
            smoothing_reg  <= 4'd2;
            flip_x_reg     <= 1'b0;
            flip_y_reg     <= 1'b0;
            fx_reg         <= '0;
            fy_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_ENABLE:     enable_reg     <= cfg_data[0];
                    REG_TARGET:     target_reg     <= cfg_data[1:0];
                    REG_CURVE:      curve_reg      <= cfg_data[1:0];
                    REG_DEAD_ZONE:  dead_zone_reg  <= cfg_data;
                    REG_FULL_SCALE: full_scale_reg <= cfg_data;
                    REG_SMOOTHING:  smoothing_reg  <= cfg_data[3:0];
                    REG_FLIP_X:     flip_x_reg     <= cfg_data[0];
                    REG_FLIP_Y:     flip_y_reg     <= cfg_data[0];
                    default:        enable_reg     <= enable_reg;
                endcase
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_xfer)
                        state_reg <= T_LANE;
                end
                T_LANE:
                begin
                    if (merge_start)
                        state_reg <= T_MERGE;
                end
                T_MERGE:
                begin
                    if (out_write)
                        state_reg <= T_IDLE;
                end
                default:
                    state_reg <= T_IDLE;
            endcase
            if (out_write)
            begin
                out_valid_reg <= 1'b1;
                if (enable_reg)
                begin
                    fx_reg <= mres.fx;
                    fy_reg <= mres.fy;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_write)
        begin
            lsx_reg <= '0;
            lsy_reg <= '0;
            rsx_reg <= '0;
            rsy_reg <= '0;
            lt_reg  <= '0;
            rt_reg  <= '0;
            if (enable_reg)
            begin
                case (target_reg)
                    TGT_LEFT:
                    begin
                        lsx_reg <= mres.fx;
                        lsy_reg <= mres.fy;
                    end
                    TGT_RIGHT:
                    begin
                        rsx_reg <= mres.fx;
                        rsy_reg <= mres.fy;
                    end
                    TGT_TRIG:
                    begin
                        lt_reg <= mres.lt;
                        rt_reg <= mres.rt;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_stick_x  = lsx_reg;
    assign left_stick_y  = lsy_reg;
    assign right_stick_x = rsx_reg;
    assign right_stick_y = rsy_reg;
    assign trig_left     = lt_reg;
    assign trig_right    = rt_reg;

`ifndef NO_ASSERTIONS
    a_rise_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == T_MERGE))
        else $error("result appeared without a finished merge");

    a_filter_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (fx_reg != $past(fx_reg) || fy_reg != $past(fy_reg)) |-> $past(out_write))
        else $error("filter state changed without a result load");

    a_load_needs_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        merge_start |-> (lane_done[0] && lane_done[1] && lane_done[2] && lane_done[3]))
        else $error("merge started before all lanes finished");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(lsx_reg) && $stable(lt_reg))
        else $error("pending result overwritten");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the analog key to gamepad axes core.
module testbench import akga_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] xn, xp, yn, yp;
    } frame_t;

    typedef struct packed {
        logic signed [15:0] lx, ly, rx, ry;
        logic [7:0]         lt, rt;
    } axes_t;

    logic clk, rst_n;
    logic cfg_write;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [7:0] travel_x_negative, travel_x_positive, travel_y_negative, travel_y_positive;
    logic signed [15:0] left_stick_x, left_stick_y, right_stick_x, right_stick_y;
    logic [7:0] trig_left, trig_right;

    analog_key_to_gamepad_axes_core uut (.*);

    logic       m_enable = 1'b1;
    logic [1:0] m_target = TGT_LEFT;
    logic [1:0] m_curve = CURVE_LIN;
    logic [7:0] m_dead = 8'd1;
    logic [7:0] m_full = 8'd40;
    logic [3:0] m_smooth = 4'd2;
    logic       m_flip_x = 1'b0;
    logic       m_flip_y = 1'b0;
    int         filt_x = 0;
    int         filt_y = 0;

    frame_t pending_frames[$];
    axes_t  expected_axes[$];
    int     errors = 0;
    int     cycles = 0;
    bit     hold_off = 0;
    bit     send_pause = 0;
    int     burst_left = 0;
    int     gap_left = 0;

    // stall value seen at the last rising edge
    logic in_stall_s;

    function automatic int key_magnitude(logic [7:0] travel);
        longint p, s, num, den, sat;
        sat = (m_full > TRAVEL_MAX) ? TRAVEL_MAX : m_full;
        if (m_dead >= sat || travel <= m_dead) return 0;
        if (travel >= sat) return 32767;
        p = travel - m_dead;
        s = sat - m_dead;
        if (m_curve == CURVE_SQR) begin
            num = p * p * 32767;
            den = s * s;
        end
        else if (m_curve == CURVE_SMOOTH) begin
            num = p * p * (3 * s - 2 * p) * 32767;
            den = s * s * s;
        end
        else begin
            num = p * 32767;
            den = s;
        end
        return int'(num / den);
    endfunction

    function automatic int smooth_toward(int prev, int goal);
        int lvl, delta, stp;
        lvl = m_smooth;
        if (lvl == 0) return goal;
        if (lvl > 10) lvl = 10;
        delta = goal - prev;
        stp = delta / (lvl + 1);
        if (stp == 0 && delta != 0) stp = delta > 0 ? 1 : -1;
        return prev + stp;
    endfunction

    function automatic logic [7:0] trigger_level(int m);
        if (m <= 0) return 8'd0;
        if (m >= 32767) return 8'd255;
        return 8'((m * 255) / 32767);
    endfunction

    function automatic axes_t predict_axes(frame_t f);
        axes_t r;
        int nx, px, ny, py, tx, ty;
        r = '0;
        if (!m_enable) return r;
        nx = key_magnitude(f.xn);
        px = key_magnitude(f.xp);
        ny = key_magnitude(f.yn);
        py = key_magnitude(f.yp);
        tx = px - nx;
        ty = py - ny;
        if (m_flip_x) tx = -tx;
        if (m_flip_y) ty = -ty;
        filt_x = smooth_toward(filt_x, tx);
        filt_y = smooth_toward(filt_y, ty);
        if (m_target == TGT_LEFT) begin
            r.lx = 16'(filt_x);
            r.ly = 16'(filt_y);
        end
        else if (m_target == TGT_RIGHT) begin
            r.rx = 16'(filt_x);
            r.ry = 16'(filt_y);
        end
        else if (m_target == TGT_TRIG) begin
            r.lt = trigger_level(nx > ny ? nx : ny);
            r.rt = trigger_level(px > py ? px : py);
        end
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) cycles <= cycles + 1;

    always @(posedge clk)
    begin
        if (cycles > 600000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall_s)
            begin
                expected_axes.push_back(predict_axes(pending_frames.pop_front()));
            end
            if (!(in_valid && in_stall_s))
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
                end
                if (pending_frames.size() > 0 && !send_pause && gap_left == 0)
                begin
                    in_valid <= 1'b1;
                    {travel_x_negative, travel_x_positive, travel_y_negative,
                     travel_y_positive} <= pending_frames[0];
                    burst_left--;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
            out_stall <= hold_off ? 1'b1 : ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk) in_stall_s <= in_stall;

    // monitor
    always @(posedge clk)
    begin
        axes_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {left_stick_x, left_stick_y, right_stick_x, right_stick_y,
                   trig_left, trig_right};
            if (expected_axes.size() == 0)
            begin
                $error("unexpected transfer %h", got);
                errors++;
            end
            else
            begin
                want = expected_axes.pop_front();
                if (got.lx !== want.lx)
                begin
                    $error("left_stick_x exp %0d got %0d", want.lx, got.lx);
                    errors++;
                end
                if (got.ly !== want.ly)
                begin
                    $error("left_stick_y exp %0d got %0d", want.ly, got.ly);
                    errors++;
                end
                if (got.rx !== want.rx)
                begin
                    $error("right_stick_x exp %0d got %0d", want.rx, got.rx);
                    errors++;
                end
                if (got.ry !== want.ry)
                begin
                    $error("right_stick_y exp %0d got %0d", want.ry, got.ry);
                    errors++;
                end
                if (got.lt !== want.lt)
                begin
                    $error("trig_left exp %0d got %0d", want.lt, got.lt);
                    errors++;
                end
                if (got.rt !== want.rt)
                begin
                    $error("trig_right exp %0d got %0d", want.rt, got.rt);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_ENABLE:     m_enable = val[0];
            REG_TARGET:     m_target = val[1:0];
            REG_CURVE:      m_curve = val[1:0];
            REG_DEAD_ZONE:  m_dead = val;
            REG_FULL_SCALE: m_full = val;
            REG_SMOOTHING:  m_smooth = val[3:0];
            REG_FLIP_X:     m_flip_x = val[0];
            REG_FLIP_Y:     m_flip_y = val[0];
            default: ;
        endcase
    endtask

    task automatic drain_frames();
        wait (pending_frames.size() == 0 && !in_valid);
        wait (expected_axes.size() == 0);
        repeat (60) @(negedge clk);
    endtask

    function automatic logic [7:0] rand_travel();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(0, 8));
            default: return 8'($urandom_range(0, 48));
        endcase
    endfunction

    task automatic queue_random(int n);
        repeat (n) pending_frames.push_back({rand_travel(), rand_travel(),
                                             rand_travel(), rand_travel()});
    endtask

    initial
    begin
        rst_n = 0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        out_stall = 0;
        {travel_x_negative, travel_x_positive, travel_y_negative, travel_y_positive} = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        pending_frames.push_back({8'd0, 8'd0, 8'd0, 8'd0});
        pending_frames.push_back({8'd255, 8'd0, 8'd0, 8'd255});
        pending_frames.push_back({8'd0, 8'd255, 8'd255, 8'd0});
        pending_frames.push_back({8'd1, 8'd2, 8'd20, 8'd39});
        pending_frames.push_back({8'd40, 8'd41, 8'd170, 8'd85});
        pending_frames.push_back({8'd255, 8'd255, 8'd255, 8'd255});
        drain_frames();
        for (int c = 0; c < 4; c++)
        begin
            write_reg(REG_CURVE, 8'(c));
            write_reg(REG_TARGET, 8'(c));
            for (int t = 0; t <= 40; t += 8)
                pending_frames.push_back({8'(t), 8'(40 - t), 8'(t / 2), 8'(t + 1)});
            drain_frames();
        end
        write_reg(REG_ENABLE, 8'd0);
        pending_frames.push_back({8'd30, 8'd10, 8'd5, 8'd35});
        drain_frames();
        write_reg(REG_ENABLE, 8'd1);
        write_reg(REG_DEAD_ZONE, 8'd50);
        pending_frames.push_back({8'd60, 8'd255, 8'd40, 8'd0});
        drain_frames();

        // long receiver hold while the sender keeps offering
        hold_off = 1;
        queue_random(20);
        repeat (400) @(negedge clk);
        hold_off = 0;
        drain_frames();

        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(REG_ENABLE, 8'($urandom_range(0, 7) != 0));
            write_reg(REG_TARGET, 8'($urandom_range(0, 3)));
            write_reg(REG_CURVE, 8'($urandom_range(0, 3)));
            write_reg(REG_DEAD_ZONE, (ph == 0) ? 8'd255 : (ph == 1) ? 8'd0
                                     : 8'($urandom_range(0, 20)));
            write_reg(REG_FULL_SCALE, (ph == 2) ? 8'd255 : (ph == 3) ? 8'd0
                                      : 8'($urandom_range(0, 60)));
            write_reg(REG_SMOOTHING, (ph == 4) ? 8'd15 : (ph == 5) ? 8'd0
                                     : 8'($urandom_range(0, 15)));
            write_reg(REG_FLIP_X, 8'($urandom_range(0, 1)));
            write_reg(REG_FLIP_Y, 8'($urandom_range(0, 1)));
            queue_random(50);
            repeat (300) @(negedge clk);
            send_pause = 1;
            wait (expected_axes.size() == 0 && !in_valid);
            send_pause = 0;
            queue_random(50);
            drain_frames();
        end

        repeat (60) @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== analog_key_to_gamepad_axes_core.f =====
hdl/akga_pkg.sv
hdl/akga_lane.sv
hdl/akga_merge.sv
hdl/analog_key_to_gamepad_axes_core.sv
bench/testbench.sv
